FILE: rtl/hsvc_pkg.sv
// Package for the HSV to RGB converter: field widths, fixed-point scale,
// hue sector constants and the sector type. No dependencies.
package hsvc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int FIELD_W   = 9;
  localparam int HUE_W     = 15;
  localparam int REM_W     = 12;
  localparam int FACT_W    = 2 * FRAC_BITS + 1;

  localparam logic [FIELD_W-1:0] ONE           = FIELD_W'(1 << FRAC_BITS);
  localparam logic [FACT_W-1:0]  ONE_SQ        = FACT_W'(1 << (2 * FRAC_BITS));
  localparam logic [HUE_W-1:0]   HUE_SECTOR    = HUE_W'(3840);
  localparam logic [HUE_W-1:0]   HUE_FULL_TURN = HUE_W'(23040);

  // floor(rem / 15) == floor(rem * 256 / 3840) for rem < 3840
  localparam int                 RECIP_SHIFT = 16;
  localparam logic [12:0]        RECIP       = 13'd4370;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [REM_W-1:0]   rem_t;
  typedef logic [FACT_W-1:0]  fact_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t sec;
    rem_t    rem;
  } sector_info_t;

endpackage

FILE: rtl/hsvc_sector.sv
// Hue sector split: wraps a hue past a full turn to zero and splits it into
// sector number and remainder within the sector. Depends on hsvc_pkg.
module hsvc_sector (
  input  logic [hsvc_pkg::HUE_W-1:0] hue,
  output hsvc_pkg::sector_info_t     info
);

  logic [hsvc_pkg::HUE_W-1:0] hue_w;
  logic [hsvc_pkg::HUE_W-1:0] base;
  logic [hsvc_pkg::HUE_W-1:0] diff;

  always_comb begin
    hue_w = (hue >= hsvc_pkg::HUE_FULL_TURN) ? '0 : hue;
    if (hue_w >= 5 * hsvc_pkg::HUE_SECTOR) begin
      info.sec = hsvc_pkg::SEC_MAG_RED;
      base     = hsvc_pkg::HUE_W'(5 * hsvc_pkg::HUE_SECTOR);
    end else if (hue_w >= 4 * hsvc_pkg::HUE_SECTOR) begin
      info.sec = hsvc_pkg::SEC_BLU_MAG;
      base     = hsvc_pkg::HUE_W'(4 * hsvc_pkg::HUE_SECTOR);
    end else if (hue_w >= 3 * hsvc_pkg::HUE_SECTOR) begin
      info.sec = hsvc_pkg::SEC_CYN_BLU;
      base     = hsvc_pkg::HUE_W'(3 * hsvc_pkg::HUE_SECTOR);
    end else if (hue_w >= 2 * hsvc_pkg::HUE_SECTOR) begin
      info.sec = hsvc_pkg::SEC_GRN_CYN;
      base     = hsvc_pkg::HUE_W'(2 * hsvc_pkg::HUE_SECTOR);
    end else if (hue_w >= hsvc_pkg::HUE_SECTOR) begin
      info.sec = hsvc_pkg::SEC_YEL_GRN;
      base     = hsvc_pkg::HUE_SECTOR;
    end else begin
      info.sec = hsvc_pkg::SEC_RED_YEL;
      base     = '0;
    end
    diff     = hue_w - base;
    info.rem = diff[hsvc_pkg::REM_W-1:0];
  end

endmodule

FILE: rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: four-stage pipeline with per-stage
// valid bits and stall back-pressure. Depends on hsvc_pkg and hsvc_sector.
//
// One pixel per clock in and out while the output is not stalled. The four
// register stages, in order, are: sector split; fraction and p product; s*f
// products; q/t products and channel select. A stalled output holds its word
// while empty stages upstream keep filling.
module hsv_to_rgb_converter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hsvc_pkg::HUE_W-1:0]   hue,
  input  logic [hsvc_pkg::FIELD_W-1:0] saturation,
  input  logic [hsvc_pkg::FIELD_W-1:0] brightness,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hsvc_pkg::FIELD_W-1:0] red,
  output logic [hsvc_pkg::FIELD_W-1:0] green,
  output logic [hsvc_pkg::FIELD_W-1:0] blue
);

  hsvc_pkg::sector_info_t info;

  logic rdy1, rdy2, rdy3, rdy4;

  logic               s1_valid;
  hsvc_pkg::sector_t  s1_sec;
  hsvc_pkg::rem_t     s1_rem;
  hsvc_pkg::field_t   s1_sat;
  hsvc_pkg::field_t   s1_val;

  logic                        s2_valid;
  hsvc_pkg::sector_t           s2_sec;
  logic [hsvc_pkg::FRAC_BITS-1:0] s2_f;
  hsvc_pkg::field_t            s2_p;
  hsvc_pkg::field_t            s2_sat;
  hsvc_pkg::field_t            s2_val;

  logic               s3_valid;
  hsvc_pkg::sector_t  s3_sec;
  hsvc_pkg::field_t   s3_p;
  hsvc_pkg::field_t   s3_val;
  hsvc_pkg::fact_t    s3_qk;
  hsvc_pkg::fact_t    s3_tk;

  hsvc_pkg::field_t   sat_c;
  logic [24:0]        f_prod;
  logic [17:0]        p_prod;
  logic [17:0]        sf_prod;
  logic [17:0]        sg_prod;
  hsvc_pkg::field_t   f_inv;
  logic [25:0]        q_prod;
  logic [25:0]        t_prod;
  hsvc_pkg::field_t   q_val;
  hsvc_pkg::field_t   t_val;
  hsvc_pkg::field_t   red_next, green_next, blue_next;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_stall = !rdy1;

  hsvc_sector u_sector (
    .hue  (hue),
    .info (info)
  );

  assign sat_c = (saturation > hsvc_pkg::ONE) ? hsvc_pkg::ONE : saturation;

  always_comb begin
    f_prod  = 25'(s1_rem) * 25'(hsvc_pkg::RECIP);
    p_prod  = 18'(s1_val) * 18'(hsvc_pkg::ONE - s1_sat);
    f_inv   = hsvc_pkg::ONE - {1'b0, s2_f};
    sf_prod = 18'(s2_sat) * 18'(s2_f);
    sg_prod = 18'(s2_sat) * 18'(f_inv);
    q_prod  = 26'(s3_val) * 26'(s3_qk);
    t_prod  = 26'(s3_val) * 26'(s3_tk);
    q_val   = q_prod[2*hsvc_pkg::FRAC_BITS +: hsvc_pkg::FIELD_W];
    t_val   = t_prod[2*hsvc_pkg::FRAC_BITS +: hsvc_pkg::FIELD_W];
    case (s3_sec)
      hsvc_pkg::SEC_RED_YEL: begin
        red_next = s3_val; green_next = t_val;  blue_next = s3_p;
      end
      hsvc_pkg::SEC_YEL_GRN: begin
        red_next = q_val;  green_next = s3_val; blue_next = s3_p;
      end
      hsvc_pkg::SEC_GRN_CYN: begin
        red_next = s3_p;   green_next = s3_val; blue_next = t_val;
      end
      hsvc_pkg::SEC_CYN_BLU: begin
        red_next = s3_p;   green_next = q_val;  blue_next = s3_val;
      end
      hsvc_pkg::SEC_BLU_MAG: begin
        red_next = t_val;  green_next = s3_p;   blue_next = s3_val;
      end
      default: begin
        red_next = s3_val; green_next = s3_p;   blue_next = q_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid  <= in_valid;
      if (rdy2) s2_valid  <= s1_valid;
      if (rdy3) s3_valid  <= s2_valid;
      if (rdy4) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_sec <= info.sec;
      s1_rem <= info.rem;
      s1_sat <= sat_c;
      s1_val <= brightness;
    end
    if (rdy2 && s1_valid) begin
      s2_sec <= s1_sec;
      s2_f   <= f_prod[hsvc_pkg::RECIP_SHIFT +: hsvc_pkg::FRAC_BITS];
      s2_p   <= p_prod[hsvc_pkg::FRAC_BITS +: hsvc_pkg::FIELD_W];
      s2_sat <= s1_sat;
      s2_val <= s1_val;
    end
    if (rdy3 && s2_valid) begin
      s3_sec <= s2_sec;
      s3_p   <= s2_p;
      s3_val <= s2_val;
      s3_qk  <= hsvc_pkg::ONE_SQ - hsvc_pkg::FACT_W'(sf_prod);
      s3_tk  <= hsvc_pkg::ONE_SQ - hsvc_pkg::FACT_W'(sg_prod);
    end
    if (rdy4 && s3_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_rem < hsvc_pkg::REM_W'(hsvc_pkg::HUE_SECTOR)))
    else $error("sector remainder out of range");

  a_p_bound: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_p <= s2_val))
    else $error("p exceeds brightness");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && rdy4) |=> out_valid)
    else $error("word lost between last stage and output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !rdy3) |=> (s2_valid && $stable(s2_p) && $stable(s2_f)))
    else $error("stalled stage changed");

endmodule

FILE: tb/sv/testbench.sv
// Testbench for hsv_to_rgb_converter: directed and random pixels checked
// against a fixed-point HSV-to-RGB predictor under random idle and stall.
// Depends on hsvc_pkg and the converter RTL.
`timescale 1ns / 1ps

module testbench;
  import hsvc_pkg::*;

  localparam int PIPE_LAT   = 4;
  localparam int TAIL_WAIT  = 2 * PIPE_LAT;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    field_t red;
    field_t green;
    field_t blue;
  } rgb_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [HUE_W-1:0]  hue = '0;
  field_t            saturation = '0;
  field_t            brightness = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  field_t            red;
  field_t            green;
  field_t            blue;

  rgb_t pending_rgb[$];
  int   error_count = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;

  hsv_to_rgb_converter DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic rgb_t hsv_to_rgb(input logic [HUE_W-1:0] h_in, input field_t s_in,
                                      input field_t v_in);
    longint unsigned one_fx;
    longint unsigned h;
    longint unsigned s;
    longint unsigned v;
    longint unsigned rem;
    longint unsigned f;
    longint unsigned p;
    longint unsigned q;
    longint unsigned t;
    sector_t         sec;
    rgb_t            rgb;
    one_fx = longint'(1) << FRAC_BITS;
    h = h_in;
    s = s_in;
    v = v_in;
    if (s > one_fx) s = one_fx;
    if (s == 0) begin
      rgb.red   = field_t'(v);
      rgb.green = field_t'(v);
      rgb.blue  = field_t'(v);
      return rgb;
    end
    if (h >= HUE_FULL_TURN) h = 0;
    sec = sector_t'(h / HUE_SECTOR);
    rem = h % HUE_SECTOR;
    f = (rem << FRAC_BITS) / HUE_SECTOR;
    p = (v * (one_fx - s)) >> FRAC_BITS;
    q = (v * (one_fx * one_fx - s * f)) >> (2 * FRAC_BITS);
    t = (v * (one_fx * one_fx - s * (one_fx - f))) >> (2 * FRAC_BITS);
    case (sec)
      SEC_RED_YEL: rgb = '{field_t'(v), field_t'(t), field_t'(p)};
      SEC_YEL_GRN: rgb = '{field_t'(q), field_t'(v), field_t'(p)};
      SEC_GRN_CYN: rgb = '{field_t'(p), field_t'(v), field_t'(t)};
      SEC_CYN_BLU: rgb = '{field_t'(p), field_t'(q), field_t'(v)};
      SEC_BLU_MAG: rgb = '{field_t'(t), field_t'(p), field_t'(v)};
      default:     rgb = '{field_t'(v), field_t'(p), field_t'(q)};
    endcase
    return rgb;
  endfunction

  // entered and left at a falling edge
  task automatic send_pixel(input logic [HUE_W-1:0] h, input field_t s, input field_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rgb.push_back(hsv_to_rgb(h, s, v));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [HUE_W-1:0] h;
    field_t           s;
    field_t           v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       h = HUE_W'($urandom_range(23040, 32767));
        1:       h = HUE_W'(HUE_SECTOR * $urandom_range(0, 6) + $urandom_range(0, 2) - 1);
        default: h = HUE_W'($urandom_range(0, 23039));
      endcase
      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = field_t'($urandom_range(257, 511));
        2:       s = ONE;
        default: s = field_t'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 9))
        0:       v = field_t'($urandom_range(257, 511));
        1:       v = $urandom_range(0, 1) ? ONE : '0;
        default: v = field_t'($urandom_range(0, 255));
      endcase
      send_pixel(h, s, v);
    end
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_pixel(15'd0,     9'd256, 9'd256);
    send_pixel(15'd3839,  9'd256, 9'd256);
    send_pixel(15'd3840,  9'd256, 9'd256);
    send_pixel(15'd7679,  9'd200, 9'd255);
    send_pixel(15'd7680,  9'd200, 9'd255);
    send_pixel(15'd11520, 9'd128, 9'd256);
    send_pixel(15'd15360, 9'd1,   9'd256);
    send_pixel(15'd19200, 9'd255, 9'd100);
    send_pixel(15'd23039, 9'd256, 9'd256);
    send_pixel(15'd23040, 9'd256, 9'd256);
    send_pixel(15'd32767, 9'd180, 9'd200);
    send_pixel(15'd5000,  9'd0,   9'd173);
    send_pixel(15'd32767, 9'd0,   9'd511);
    send_pixel(15'd9000,  9'd257, 9'd256);
    send_pixel(15'd13000, 9'd511, 9'd511);
    send_pixel(15'd17000, 9'd256, 9'd511);
    send_pixel(15'd21000, 9'd300, 9'd0);
    send_pixel(15'd0,     9'd0,   9'd0);
    send_pixel(15'd1920,  9'd128, 9'd128);
    send_pixel(15'd22000, 9'd256, 9'd257);
    wait_drained();
  endtask

  task automatic test_random_phase(input int count, input int idle_p, input int stall_p);
    idle_pct  = idle_p;
    stall_pct = stall_p;
    send_random(count);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    idle_pct  = 0;
    stall_pct = 32;
    send_random(12);
    wait_drained();
    send_random(12);
    wait_drained();
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected word r=%0d g=%0d b=%0d", $time, red, green, blue);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, red);
          error_count++;
        end
        if (green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, green);
          error_count++;
        end
        if (blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, blue);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phase(120, 0, 0);
    test_random_phase(120, 63, 0);
    test_random_phase(120, 0, 63);
    test_random_phase(120, 32, 32);
    test_drain_pause();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
